### src/sha256_stream_hasher_assert.svh
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Implication checks on the block clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// same-cycle implication
`define SHA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Types, round constants and round functions shared by the hasher modules.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PB_DATA,
    PB_MARK,
    PB_ZERO,
    PB_LEN
  } pad_kind_t;

  typedef struct packed {
    logic      shift_byte;
    pad_kind_t pad_kind;
    logic      comp_init;
    logic      round;
    logic [5:0] round_idx;
    logic      fin;
    logic      restart;
    logic [1:0] part;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_lt56;
    logic fill_ge56;
  } sts_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [1:0] LAST_PART = 2'd3;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### src/sha256_if.sv
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for message bytes and digest parts.
// ----------------------------------------------------------------------------
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_part;
  logic [1:0]  part_index;
  logic        last_part;

  modport source (output valid, digest_part, part_index, last_part, input ready);
  modport sink (input valid, digest_part, part_index, last_part, output ready);
endinterface

### src/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_byte_present,
  input  logic               in_eom,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  input  sha256_pkg::sts_t   sts,
  output sha256_pkg::cmd_t   cmd
);

  sha256_pkg::state_t state_r, state_nxt;
  logic [5:0] rnd_r;
  logic [1:0] part_r;
  logic       pad_r;
  logic       sent80_r;
  logic       len_ok_r;
  logic       take;
  logic       done;

  assign take = in_valid && (state_r == sha256_pkg::ST_IDLE);
  assign done = (state_r == sha256_pkg::ST_OUT) && out_ready &&
                (part_r == sha256_pkg::LAST_PART);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_byte_present && sts.fill_last) state_nxt = sha256_pkg::ST_COMP;
          else if (in_eom) state_nxt = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_PAD: begin
        if (sts.fill_last) state_nxt = sha256_pkg::ST_COMP;
      end
      sha256_pkg::ST_COMP: begin
        if (rnd_r == sha256_pkg::LAST_ROUND) state_nxt = sha256_pkg::ST_FIN;
      end
      sha256_pkg::ST_FIN: begin
        if (pad_r && len_ok_r) state_nxt = sha256_pkg::ST_OUT;
        else if (pad_r) state_nxt = sha256_pkg::ST_PAD;
        else state_nxt = sha256_pkg::ST_IDLE;
      end
      sha256_pkg::ST_OUT: begin
        if (done) state_nxt = sha256_pkg::ST_IDLE;
      end
      default: state_nxt = sha256_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == sha256_pkg::ST_IDLE);
    out_valid      = (state_r == sha256_pkg::ST_OUT);
    cmd            = '0;
    cmd.pad_kind   = sha256_pkg::PB_DATA;
    cmd.round_idx  = rnd_r;
    cmd.part       = part_r;
    cmd.fin        = (state_r == sha256_pkg::ST_FIN);
    cmd.round      = (state_r == sha256_pkg::ST_COMP);
    cmd.restart    = done;
    unique case (state_r)
      sha256_pkg::ST_IDLE: begin
        cmd.shift_byte = take && in_byte_present;
      end
      sha256_pkg::ST_PAD: begin
        cmd.shift_byte = 1'b1;
        if (!sent80_r) cmd.pad_kind = sha256_pkg::PB_MARK;
        else if (len_ok_r && sts.fill_ge56) cmd.pad_kind = sha256_pkg::PB_LEN;
        else cmd.pad_kind = sha256_pkg::PB_ZERO;
      end
      default: cmd.shift_byte = 1'b0;
    endcase
    cmd.comp_init = cmd.shift_byte && sts.fill_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sha256_pkg::ST_IDLE;
      rnd_r    <= '0;
      part_r   <= '0;
      pad_r    <= 1'b0;
      sent80_r <= 1'b0;
      len_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= (state_r == sha256_pkg::ST_COMP) ? rnd_r + 6'd1 : '0;
      if (out_valid && out_ready) part_r <= part_r + 2'd1;
      if (take && in_eom) pad_r <= 1'b1;
      if (state_r == sha256_pkg::ST_PAD && !sent80_r) begin
        sent80_r <= 1'b1;
        len_ok_r <= sts.fill_lt56;
      end
      if (state_r == sha256_pkg::ST_FIN && pad_r && sent80_r) len_ok_r <= 1'b1;
      if (done) begin
        pad_r    <= 1'b0;
        sent80_r <= 1'b0;
        len_ok_r <= 1'b0;
        part_r   <= '0;
      end
    end
  end

endmodule

### src/sha256_dp.sv
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block shift register with message schedule, round registers, hash words.
// ----------------------------------------------------------------------------
module sha256_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       data_byte,
  input  sha256_pkg::cmd_t cmd,
  output sha256_pkg::sts_t sts,
  output logic [63:0]      digest_part
);

  logic [511:0] blk_r;
  logic [5:0]   fill_r;
  logic [63:0]  bits_r;
  logic [255:0] h_r;
  logic [31:0]  v_r [8];
  logic [7:0]   byte_in;
  logic [5:0]   len_sh;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  t1, t2, ch, maj;
  logic [7:0]   part_sh;

  assign sts.fill_last = (fill_r == 6'd63);
  assign sts.fill_lt56 = (fill_r < 6'd56);
  assign sts.fill_ge56 = (fill_r >= 6'd56);

  assign len_sh = {~fill_r[2:0], 3'b000};
  assign part_sh = {~cmd.part, 6'b000000};
  assign digest_part = h_r[part_sh +: 64];

  always_comb begin
    unique case (cmd.pad_kind)
      sha256_pkg::PB_DATA: byte_in = data_byte;
      sha256_pkg::PB_MARK: byte_in = sha256_pkg::PAD_MARK;
      sha256_pkg::PB_ZERO: byte_in = 8'h00;
      sha256_pkg::PB_LEN:  byte_in = bits_r[len_sh +: 8];
      default:             byte_in = 8'h00;
    endcase
  end

  assign w0  = blk_r[511:480];
  assign w1  = blk_r[479:448];
  assign w9  = blk_r[223:192];
  assign w14 = blk_r[63:32];
  assign w_new = sha256_pkg::ssig1(w14) + w9 + sha256_pkg::ssig0(w1) + w0;

  assign ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1  = v_r[7] + sha256_pkg::bsig1(v_r[4]) + ch +
               sha256_pkg::round_k(cmd.round_idx) + w0;
  assign t2  = sha256_pkg::bsig0(v_r[0]) + maj;

  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      blk_r <= {blk_r[503:0], byte_in};
    end else if (cmd.round) begin
      blk_r <= {blk_r[479:0], w_new};
    end
    if (cmd.comp_init) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[32*(7-i) +: 32];
    end else if (cmd.round) begin
      v_r[0] <= t1 + t2;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= v_r[4];
      v_r[6] <= v_r[5];
      v_r[7] <= v_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      bits_r <= '0;
      h_r    <= sha256_pkg::H_INIT;
    end else begin
      if (cmd.shift_byte) begin
        fill_r <= fill_r + 6'd1;
        if (cmd.pad_kind == sha256_pkg::PB_DATA) bits_r <= bits_r + 64'd8;
      end
      if (cmd.fin) begin
        for (int i = 0; i < 8; i++) h_r[32*(7-i) +: 32] <= h_r[32*(7-i) +: 32] + v_r[i];
      end
      if (cmd.restart) begin
        fill_r <= '0;
        bits_r <= '0;
        h_r    <= sha256_pkg::H_INIT;
      end
    end
  end

endmodule

### src/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the digest as four 64-bit parts.
// ----------------------------------------------------------------------------
// in_stream: one item per transfer; data_byte counts when byte_present is
//   set, end_of_message closes the message (it may carry no byte).
// out_stream: four transfers per message, part 0 (most significant) first,
//   last_part set on part 3.
// The 64th byte of a block starts a compression: 64 rounds of the single
//   round unit, then a hash update.
// End of message: padding shifts one byte a cycle into the block register,
//   then one or two compressions, then the digest.
// in_ready is low from end of message until part 3 is transferred.
// A stalled receiver holds the current part; nothing else advances.
// Reset loads the initial hash values and clears the byte and bit counts.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_assert.svh"

module sha256_stream_hasher (
  input logic         clk,
  input logic         rst_n,
  sha256_in_if.sink   in_stream,
  sha256_out_if.source out_stream
);

  sha256_pkg::cmd_t cmd;
  sha256_pkg::sts_t sts;

  sha256_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_stream.valid),
    .in_byte_present (in_stream.byte_present),
    .in_eom          (in_stream.end_of_message),
    .in_ready        (in_stream.ready),
    .out_ready       (out_stream.ready),
    .out_valid       (out_stream.valid),
    .sts             (sts),
    .cmd             (cmd)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .data_byte   (in_stream.data_byte),
    .cmd         (cmd),
    .sts         (sts),
    .digest_part (out_stream.digest_part)
  );

  assign out_stream.part_index = cmd.part;
  assign out_stream.last_part  = (cmd.part == sha256_pkg::LAST_PART);

  `SHA_ASSERT_NOW(a_no_overlap, out_stream.valid, !in_stream.ready)
  `SHA_ASSERT_NEXT(a_ready_after_digest,
    out_stream.valid && out_stream.ready && out_stream.last_part, in_stream.ready)
  `SHA_ASSERT_NEXT(a_idle_item,
    in_stream.valid && in_stream.ready && !in_stream.byte_present &&
    !in_stream.end_of_message, in_stream.ready)

endmodule
